### rtl/core/fwoi_pkg.sv
// -----------------------------------------------------------------------------
// Four-wheel odometry integrator package
// Widths, codes, payload types and the control types of the shared
// shift-add/subtract unit.
// -----------------------------------------------------------------------------
package fwoi_pkg;

  localparam int unsigned READ_W     = 32;
  localparam int unsigned POS_W      = 48;
  localparam int unsigned SPD_W      = 32;

  localparam int unsigned RATIO_W    = 16;
  localparam int unsigned SPACING_W  = 21;
  localparam int unsigned PERIOD_W   = 20;
  localparam int unsigned CFG_DATA_W = 21;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam int unsigned ACC_W      = 58;
  localparam int unsigned SR_W       = 49;
  localparam int unsigned OPND_W     = 35;
  localparam int unsigned REM_W      = 29;
  localparam int unsigned CNT_W      = 6;

  localparam logic [7:0] HEADER_ODOM = 8'h44;

  localparam logic [CFG_IDX_W-1:0] REG_UNIT_RATIO    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_SPACING = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd2;

  localparam logic [RATIO_W-1:0]   RATIO_RST   = 16'd1000;
  localparam logic [SPACING_W-1:0] SPACING_RST = 21'd13107;
  localparam logic [PERIOD_W-1:0]  PERIOD_RST  = 20'd50000;

  typedef struct packed {
    logic [7:0]               header_byte;
    logic                     frame_complete;
    logic signed [READ_W-1:0] left_front_reading;
    logic signed [READ_W-1:0] right_front_reading;
    logic signed [READ_W-1:0] left_back_reading;
    logic signed [READ_W-1:0] right_back_reading;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position_x;
    logic signed [POS_W-1:0] position_y;
    logic signed [POS_W-1:0] heading;
    logic signed [SPD_W-1:0] speed_x;
    logic signed [SPD_W-1:0] speed_y;
    logic signed [SPD_W-1:0] turn_rate;
  } out_item_t;

  typedef struct packed {
    logic [RATIO_W-1:0]   unit_ratio;
    logic [SPACING_W-1:0] wheel_spacing;
    logic [PERIOD_W-1:0]  sample_period_us;
  } cfg_t;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef struct packed {
    logic              start;
    alu_op_e           op;
    logic [CNT_W-1:0]  steps;
    logic [ACC_W-1:0]  acc_init;
    logic [SR_W-1:0]   sr_init;
    logic [OPND_W-1:0] opnd;
  } alu_cmd_t;

  typedef struct packed {
    logic             done;
    logic [ACC_W-1:0] acc;
    logic [SR_W-1:0]  sr;
  } alu_stat_t;

endpackage

### rtl/core/fwoi_alu.sv
// -----------------------------------------------------------------------------
// Shared shift-add/subtract unit
// One bit per cycle: MSB-first shift-add multiply or restoring divide, with
// the remainder kept in the accumulator and quotient bits shifted into sr.
// -----------------------------------------------------------------------------
module fwoi_alu (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fwoi_pkg::alu_cmd_t  cmd_i,
  output fwoi_pkg::alu_stat_t stat_o
);

  logic [fwoi_pkg::ACC_W-1:0]  acc_q, acc_d;
  logic [fwoi_pkg::SR_W-1:0]   sr_q, sr_d;
  logic [fwoi_pkg::OPND_W-1:0] opnd_q;
  fwoi_pkg::alu_op_e           op_q;
  logic [fwoi_pkg::CNT_W-1:0]  cnt_q;
  logic                        busy_q;
  logic                        done_q;

  logic [fwoi_pkg::REM_W:0]    rem_sh;
  logic [fwoi_pkg::ACC_W-1:0]  add_a, add_b;
  logic                        add_cin;
  logic [fwoi_pkg::ACC_W:0]    sum;

  always_comb begin
    rem_sh = {acc_q[fwoi_pkg::REM_W-1:0], sr_q[fwoi_pkg::SR_W-1]};
    if (op_q == fwoi_pkg::ALU_DIV) begin
      add_a   = {{(fwoi_pkg::ACC_W-fwoi_pkg::REM_W-1){1'b0}}, rem_sh};
      add_b   = ~{{(fwoi_pkg::ACC_W-fwoi_pkg::OPND_W){1'b0}}, opnd_q};
      add_cin = 1'b1;
    end else begin
      add_a   = {acc_q[fwoi_pkg::ACC_W-2:0], 1'b0};
      add_b   = sr_q[fwoi_pkg::SR_W-1] ?
                {{(fwoi_pkg::ACC_W-fwoi_pkg::OPND_W){1'b0}}, opnd_q} : '0;
      add_cin = 1'b0;
    end
    sum = {1'b0, add_a} + {1'b0, add_b} + {{fwoi_pkg::ACC_W{1'b0}}, add_cin};
    if (op_q == fwoi_pkg::ALU_DIV) begin
      acc_d = sum[fwoi_pkg::ACC_W] ? sum[fwoi_pkg::ACC_W-1:0] : add_a;
      sr_d  = {sr_q[fwoi_pkg::SR_W-2:0], sum[fwoi_pkg::ACC_W]};
    end else begin
      acc_d = sum[fwoi_pkg::ACC_W-1:0];
      sr_d  = {sr_q[fwoi_pkg::SR_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= cmd_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - fwoi_pkg::CNT_W'(1);
        if (cnt_q == fwoi_pkg::CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      acc_q  <= cmd_i.acc_init;
      sr_q   <= cmd_i.sr_init;
      opnd_q <= cmd_i.opnd;
      op_q   <= cmd_i.op;
    end else if (busy_q) begin
      acc_q <= acc_d;
      sr_q  <= sr_d;
    end
  end

  always_comb begin
    stat_o.done = done_q;
    stat_o.acc  = acc_q;
    stat_o.sr   = sr_q;
  end

endmodule

### rtl/core/fwoi_seq.sv
// -----------------------------------------------------------------------------
// Odometry sequencer
// Runs one frame through the shared unit: wheel scaling, mixing, pose
// increments, accumulation and velocities. Holds the odometry state.
// -----------------------------------------------------------------------------
module fwoi_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  fwoi_pkg::in_item_t  item_i,
  input  fwoi_pkg::cfg_t      cfg_i,
  output logic                idle_o,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output fwoi_pkg::out_item_t res_o
);

  localparam int unsigned KC_W    = 22;
  localparam int unsigned US_W    = 20;
  localparam int unsigned SUM_W   = 36;
  localparam int unsigned DLT_W   = 33;
  localparam int unsigned CLAMP_W = 34;
  localparam int unsigned QSH     = 24;
  localparam int unsigned VSH     = 32;

  localparam logic [KC_W-1:0]    KX       = 22'd2154774;
  localparam logic [KC_W-1:0]    KY       = 22'd3471235;
  localparam logic [KC_W-1:0]    KW       = 22'd4085648;
  localparam logic [US_W-1:0]    US_PER_S = 20'd1000000;
  localparam logic [CLAMP_W-1:0] VCLAMP   = 34'h2_0000_0000;
  localparam logic [3:0]         SX_SUB   = 4'b1010;
  localparam logic [3:0]         SY_SUB   = 4'b0011;
  localparam logic [3:0]         SW_SUB   = 4'b1111;
  localparam logic [fwoi_pkg::ACC_W-1:0] HALF_Q24 =
    {{(fwoi_pkg::ACC_W-QSH){1'b0}}, 1'b1, {(QSH-1){1'b0}}};
  localparam logic [fwoi_pkg::SPD_W-1:0] SPD_MAX = 32'h7FFF_FFFF;
  localparam logic [fwoi_pkg::SPD_W-1:0] SPD_MIN = 32'h8000_0000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIVR,
    S_SUM,
    S_MULX,
    S_MULY,
    S_MULH,
    S_DIVH,
    S_MULV,
    S_DIVV,
    S_OUT
  } state_e;

  state_e                          state_q;
  logic                            go_q;
  logic [1:0]                      idx_q;
  logic [1:0]                      vidx_q;
  logic [fwoi_pkg::READ_W-1:0]     rd_q     [4];
  logic [fwoi_pkg::READ_W-1:0]     scaled_q [4];
  logic [fwoi_pkg::READ_W-1:0]     prev_q   [4];
  logic                            first_q;
  logic [SUM_W-1:0]                sx_q, sy_q, sw_q;
  logic                            dneg_q   [3];
  logic [fwoi_pkg::SR_W-1:0]       dmag_q   [3];
  logic [fwoi_pkg::SPD_W-1:0]      spd_q    [3];
  logic [fwoi_pkg::POS_W-1:0]      accx_q, accy_q, acch_q;

  fwoi_pkg::alu_cmd_t              cmd;
  fwoi_pkg::alu_stat_t             stat;

  logic [fwoi_pkg::READ_W-1:0]     rd_cur, rd_mag, quo32, scaled_new, prev_sel;
  logic [DLT_W-1:0]                delta;
  logic [SUM_W-1:0]                dsext, sx_abs, sy_abs, sw_abs;
  logic [CLAMP_W-1:0]              qmag, vclamp;
  logic [fwoi_pkg::SR_W-1:0]       vmag;
  logic [fwoi_pkg::ACC_W-1:0]      dvd_bias, dvd;
  logic                            sat_v;
  logic [fwoi_pkg::SPD_W-1:0]      spd_new;

  fwoi_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

  always_comb begin
    rd_cur     = rd_q[idx_q];
    rd_mag     = rd_cur[fwoi_pkg::READ_W-1] ? (~rd_cur + 32'd1) : rd_cur;
    quo32      = stat.sr[fwoi_pkg::READ_W-1:0];
    scaled_new = rd_cur[fwoi_pkg::READ_W-1] ? (~quo32 + 32'd1) : quo32;
    prev_sel   = first_q ? '0 : prev_q[idx_q];
    delta      = {scaled_q[idx_q][fwoi_pkg::READ_W-1], scaled_q[idx_q]}
               - {prev_sel[fwoi_pkg::READ_W-1], prev_sel};
    dsext      = {{(SUM_W-DLT_W){delta[DLT_W-1]}}, delta};
    sx_abs     = sx_q[SUM_W-1] ? (~sx_q + 36'd1) : sx_q;
    sy_abs     = sy_q[SUM_W-1] ? (~sy_q + 36'd1) : sy_q;
    sw_abs     = sw_q[SUM_W-1] ? (~sw_q + 36'd1) : sw_q;
    qmag       = stat.acc[fwoi_pkg::ACC_W-1:QSH];
    vmag       = dmag_q[vidx_q];
    vclamp     = (vmag > fwoi_pkg::SR_W'(VCLAMP)) ? VCLAMP : vmag[CLAMP_W-1:0];
    dvd_bias   = (state_q == S_DIVH)
               ? fwoi_pkg::ACC_W'({cfg_i.wheel_spacing, 7'b0})
               : fwoi_pkg::ACC_W'(cfg_i.sample_period_us >> 1);
    dvd        = stat.acc + dvd_bias;
    sat_v      = dvd[fwoi_pkg::ACC_W-1:VSH]
               >= (fwoi_pkg::ACC_W-VSH)'(cfg_i.sample_period_us);
    if (dneg_q[vidx_q]) begin
      spd_new = (quo32[31] && (quo32[30:0] != '0)) ? SPD_MIN : (~quo32 + 32'd1);
    end else begin
      spd_new = quo32[31] ? SPD_MAX : quo32;
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.start = go_q;
    cmd.op    = fwoi_pkg::ALU_MUL;
    case (state_q)
      S_DIVR: begin
        cmd.op      = fwoi_pkg::ALU_DIV;
        cmd.steps   = fwoi_pkg::CNT_W'(fwoi_pkg::READ_W);
        cmd.sr_init = {rd_mag, {(fwoi_pkg::SR_W-fwoi_pkg::READ_W){1'b0}}};
        cmd.opnd    = fwoi_pkg::OPND_W'(cfg_i.unit_ratio);
      end
      S_MULX: begin
        cmd.steps    = fwoi_pkg::CNT_W'(KC_W);
        cmd.acc_init = HALF_Q24 >> KC_W;
        cmd.sr_init  = {KX, {(fwoi_pkg::SR_W-KC_W){1'b0}}};
        cmd.opnd     = fwoi_pkg::OPND_W'(sx_abs);
      end
      S_MULY: begin
        cmd.steps    = fwoi_pkg::CNT_W'(KC_W);
        cmd.acc_init = HALF_Q24 >> KC_W;
        cmd.sr_init  = {KY, {(fwoi_pkg::SR_W-KC_W){1'b0}}};
        cmd.opnd     = fwoi_pkg::OPND_W'(sy_abs);
      end
      S_MULH: begin
        cmd.steps    = fwoi_pkg::CNT_W'(KC_W);
        cmd.sr_init  = {KW, {(fwoi_pkg::SR_W-KC_W){1'b0}}};
        cmd.opnd     = fwoi_pkg::OPND_W'(sw_abs);
      end
      S_DIVH: begin
        cmd.op       = fwoi_pkg::ALU_DIV;
        cmd.steps    = fwoi_pkg::CNT_W'(fwoi_pkg::SR_W);
        cmd.acc_init = dvd >> fwoi_pkg::SR_W;
        cmd.sr_init  = dvd[fwoi_pkg::SR_W-1:0];
        cmd.opnd     = fwoi_pkg::OPND_W'({cfg_i.wheel_spacing, 8'b0});
      end
      S_MULV: begin
        cmd.steps    = fwoi_pkg::CNT_W'(US_W);
        cmd.sr_init  = {US_PER_S, {(fwoi_pkg::SR_W-US_W){1'b0}}};
        cmd.opnd     = fwoi_pkg::OPND_W'(vclamp);
      end
      S_DIVV: begin
        cmd.op       = fwoi_pkg::ALU_DIV;
        cmd.steps    = fwoi_pkg::CNT_W'(VSH);
        cmd.acc_init = dvd >> VSH;
        cmd.sr_init  = {dvd[VSH-1:0], {(fwoi_pkg::SR_W-VSH){1'b0}}};
        cmd.opnd     = fwoi_pkg::OPND_W'(cfg_i.sample_period_us);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      go_q    <= 1'b0;
      idx_q   <= '0;
      vidx_q  <= '0;
      first_q <= 1'b1;
      sx_q    <= '0;
      sy_q    <= '0;
      sw_q    <= '0;
      accx_q  <= '0;
      accy_q  <= '0;
      acch_q  <= '0;
      for (int i = 0; i < 4; i++) begin
        rd_q[i]     <= '0;
        scaled_q[i] <= '0;
        prev_q[i]   <= '0;
      end
      for (int j = 0; j < 3; j++) begin
        dneg_q[j] <= 1'b0;
        dmag_q[j] <= '0;
        spd_q[j]  <= '0;
      end
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            rd_q[0] <= item_i.left_front_reading;
            rd_q[1] <= item_i.right_front_reading;
            rd_q[2] <= item_i.left_back_reading;
            rd_q[3] <= item_i.right_back_reading;
            sx_q    <= '0;
            sy_q    <= '0;
            sw_q    <= '0;
            idx_q   <= '0;
            go_q    <= 1'b1;
            state_q <= S_DIVR;
          end
        end
        S_DIVR: begin
          go_q <= 1'b0;
          if (stat.done) begin
            scaled_q[idx_q] <= scaled_new;
            if (idx_q == 2'd3) begin
              idx_q   <= '0;
              state_q <= S_SUM;
            end else begin
              idx_q <= idx_q + 2'd1;
              go_q  <= 1'b1;
            end
          end
        end
        S_SUM: begin
          sx_q          <= SX_SUB[idx_q] ? (sx_q - dsext) : (sx_q + dsext);
          sy_q          <= SY_SUB[idx_q] ? (sy_q - dsext) : (sy_q + dsext);
          sw_q          <= SW_SUB[idx_q] ? (sw_q - dsext) : (sw_q + dsext);
          prev_q[idx_q] <= scaled_q[idx_q];
          if (idx_q == 2'd3) begin
            first_q <= 1'b0;
            go_q    <= 1'b1;
            state_q <= S_MULX;
          end else begin
            idx_q <= idx_q + 2'd1;
          end
        end
        S_MULX: begin
          go_q <= 1'b0;
          if (stat.done) begin
            dmag_q[0] <= fwoi_pkg::SR_W'(qmag);
            dneg_q[0] <= sx_q[SUM_W-1];
            accx_q    <= sx_q[SUM_W-1] ? (accx_q - fwoi_pkg::POS_W'(qmag))
                                       : (accx_q + fwoi_pkg::POS_W'(qmag));
            go_q      <= 1'b1;
            state_q   <= S_MULY;
          end
        end
        S_MULY: begin
          go_q <= 1'b0;
          if (stat.done) begin
            dmag_q[1] <= fwoi_pkg::SR_W'(qmag);
            dneg_q[1] <= sy_q[SUM_W-1];
            accy_q    <= sy_q[SUM_W-1] ? (accy_q - fwoi_pkg::POS_W'(qmag))
                                       : (accy_q + fwoi_pkg::POS_W'(qmag));
            go_q      <= 1'b1;
            state_q   <= S_MULH;
          end
        end
        S_MULH: begin
          go_q <= 1'b0;
          if (stat.done) begin
            go_q    <= 1'b1;
            state_q <= S_DIVH;
          end
        end
        S_DIVH: begin
          go_q <= 1'b0;
          if (stat.done) begin
            dmag_q[2] <= stat.sr;
            dneg_q[2] <= sw_q[SUM_W-1];
            acch_q    <= sw_q[SUM_W-1] ? (acch_q - stat.sr[fwoi_pkg::POS_W-1:0])
                                       : (acch_q + stat.sr[fwoi_pkg::POS_W-1:0]);
            vidx_q    <= '0;
            go_q      <= 1'b1;
            state_q   <= S_MULV;
          end
        end
        S_MULV: begin
          go_q <= 1'b0;
          if (stat.done) begin
            if (sat_v) begin
              spd_q[vidx_q] <= dneg_q[vidx_q] ? SPD_MIN : SPD_MAX;
              if (vidx_q == 2'd2) begin
                state_q <= S_OUT;
              end else begin
                vidx_q <= vidx_q + 2'd1;
                go_q   <= 1'b1;
              end
            end else begin
              go_q    <= 1'b1;
              state_q <= S_DIVV;
            end
          end
        end
        S_DIVV: begin
          go_q <= 1'b0;
          if (stat.done) begin
            spd_q[vidx_q] <= spd_new;
            if (vidx_q == 2'd2) begin
              state_q <= S_OUT;
            end else begin
              vidx_q  <= vidx_q + 2'd1;
              go_q    <= 1'b1;
              state_q <= S_MULV;
            end
          end
        end
        S_OUT: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          go_q    <= 1'b0;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    idle_o           = (state_q == S_IDLE);
    res_valid_o      = (state_q == S_OUT);
    res_o.position_x = accx_q;
    res_o.position_y = accy_q;
    res_o.heading    = acch_q;
    res_o.speed_x    = spd_q[0];
    res_o.speed_y    = spd_q[1];
    res_o.turn_rate  = spd_q[2];
  end

endmodule

### rtl/core/four_wheel_odometry_integrator.sv
// -----------------------------------------------------------------------------
// Four-wheel odometry integrator
// Dead-reckons a mecanum base from frames of four cumulative wheel readings
// (Q16.16). A frame transfer with header 0x44 and frame_complete set yields
// one result: x, y and heading accumulated in wrapping Q32.16, and saturated
// Q16.16 x, y and yaw rates. Other frames are taken and dropped. The
// multiplies and divides run through one shift-add/subtract unit that retires
// one multiplier or quotient bit per cycle: four 32-step divides by
// unit_ratio, three 22-step constant multiplies, a 49-step heading divide,
// and for each rate a 20-step multiply plus a 32-step divide by
// sample_period_us; a rate that saturates skips its divide. A valid frame
// holds the input until its result loads into the result register. The
// result register frees the sequencer as soon as it loads, so the next frame
// transfer can start while a result still waits downstream. A zero register
// value acts as one.
// -----------------------------------------------------------------------------
module four_wheel_odometry_integrator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [fwoi_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [fwoi_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  fwoi_pkg::in_item_t                 in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output fwoi_pkg::out_item_t                out_item_o
);

  logic [fwoi_pkg::RATIO_W-1:0]   ratio_q;
  logic [fwoi_pkg::SPACING_W-1:0] spacing_q;
  logic [fwoi_pkg::PERIOD_W-1:0]  period_q;
  fwoi_pkg::cfg_t                 cfg_eff;

  logic                           seq_idle;
  logic                           seq_start;
  logic                           frame_ok;
  logic                           res_valid;
  logic                           load_ok;
  fwoi_pkg::out_item_t            res;

  logic                           out_valid_q;
  fwoi_pkg::out_item_t            out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q   <= fwoi_pkg::RATIO_RST;
      spacing_q <= fwoi_pkg::SPACING_RST;
      period_q  <= fwoi_pkg::PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        fwoi_pkg::REG_UNIT_RATIO:    ratio_q   <= cfg_data_i[fwoi_pkg::RATIO_W-1:0];
        fwoi_pkg::REG_WHEEL_SPACING: spacing_q <= cfg_data_i[fwoi_pkg::SPACING_W-1:0];
        fwoi_pkg::REG_SAMPLE_PERIOD: period_q  <= cfg_data_i[fwoi_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_eff.unit_ratio       = (ratio_q == '0) ? fwoi_pkg::RATIO_W'(1) : ratio_q;
    cfg_eff.wheel_spacing    = (spacing_q == '0) ? fwoi_pkg::SPACING_W'(1) : spacing_q;
    cfg_eff.sample_period_us = (period_q == '0) ? fwoi_pkg::PERIOD_W'(1) : period_q;
  end

  assign in_ready_o = seq_idle;
  assign frame_ok   = (in_item_i.header_byte == fwoi_pkg::HEADER_ODOM)
                    && in_item_i.frame_complete;
  assign seq_start  = in_valid_i && in_ready_o && frame_ok;
  assign load_ok    = !out_valid_q || out_ready_i;

  fwoi_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (seq_start),
    .item_i      (in_item_i),
    .cfg_i       (cfg_eff),
    .idle_o      (seq_idle),
    .res_valid_o (res_valid),
    .res_ready_i (load_ok),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && load_ok) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && load_ok) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
